@@ hdl/edf_unit_task_scheduler_core_assert.svh @@
// assertion macros for the scheduler core rtl
// expects clk and rst_n in the including scope
`ifndef EDF_UNIT_TASK_SCHEDULER_CORE_ASSERT_SVH
`define EDF_UNIT_TASK_SCHEDULER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EDFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edfs check failed");

// antecedent implies consequent in the next cycle
`define EDFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edfs check failed");

`endif

@@ hdl/edfs_pkg.sv @@
// shared types and constants for the edf task scheduler
// no dependencies
`timescale 1ns / 1ps

package edfs_pkg;

    localparam int KIND_W = 3;
    localparam int WORK_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDLE     = 3'd0,
        KIND_WORK     = 3'd1,
        KIND_DEADLINE = 3'd2,
        KIND_ACCEPT   = 3'd3,
        KIND_REJECT   = 3'd4
    } kind_t;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic elig_en;
        logic ins_en;
        logic dec_en;
    } cell_ctl_t;

endpackage

@@ hdl/edfs_cell.sv @@
// one slot of the deadline-sorted task chain
// depends on edfs_pkg
`timescale 1ns / 1ps

module edfs_cell
    import edfs_pkg::*;
#(
    parameter int DAY_BITS = 8,
    parameter int ID_W     = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctl_t           ctl,
    input  logic [DAY_BITS-1:0] check_day,
    input  logic [DAY_BITS-1:0] new_rel,
    input  logic [DAY_BITS-1:0] new_dl,
    input  logic [WORK_W-1:0]   new_rem,
    input  logic [ID_W-1:0]     new_id,
    input  logic                prev_occ,
    input  logic                prev_live,
    input  logic [DAY_BITS-1:0] prev_rel,
    input  logic [DAY_BITS-1:0] prev_dl,
    input  logic [WORK_W-1:0]   prev_rem,
    input  logic [ID_W-1:0]     prev_id,
    input  logic                prev_ins,
    input  logic                found_in,
    output logic                occ,
    output logic                live,
    output logic [DAY_BITS-1:0] rel,
    output logic [DAY_BITS-1:0] dl,
    output logic [WORK_W-1:0]   rem,
    output logic [ID_W-1:0]     id,
    output logic                ins_flag,
    output logic                found_out,
    output logic                hit,
    output logic                last
);

    logic                occ_reg, occ_next;
    logic                live_reg, live_next;
    logic                elig_reg, elig_next;
    logic [DAY_BITS-1:0] rel_reg, rel_next;
    logic [DAY_BITS-1:0] dl_reg, dl_next;
    logic [WORK_W-1:0]   rem_reg, rem_next;
    logic [ID_W-1:0]     id_reg, id_next;

    // new task sorts ahead of this slot; equal deadlines stay behind older ids
    assign ins_flag  = !occ_reg || (new_dl < dl_reg);
    assign hit       = elig_reg && !found_in;
    assign found_out = found_in || elig_reg;
    assign last      = (rem_reg == WORK_W'(1));

    assign occ  = occ_reg;
    assign live = live_reg;
    assign rel  = rel_reg;
    assign dl   = dl_reg;
    assign rem  = rem_reg;
    assign id   = id_reg;

    always_comb
    begin
        occ_next  = occ_reg;
        live_next = live_reg;
        elig_next = elig_reg;
        rel_next  = rel_reg;
        dl_next   = dl_reg;
        rem_next  = rem_reg;
        id_next   = id_reg;
        if (ctl.elig_en)
        begin
            elig_next = live_reg && (rel_reg <= check_day) && (dl_reg > check_day);
        end
        if (ctl.ins_en && ins_flag)
        begin
            if (prev_ins)
            begin
                // shift down from the neighbor
                occ_next  = prev_occ;
                live_next = prev_live;
                rel_next  = prev_rel;
                dl_next   = prev_dl;
                rem_next  = prev_rem;
                id_next   = prev_id;
            end
            else
            begin
                occ_next  = 1'b1;
                live_next = 1'b1;
                rel_next  = new_rel;
                dl_next   = new_dl;
                rem_next  = new_rem;
                id_next   = new_id;
            end
        end
        if (ctl.dec_en && hit)
        begin
            rem_next = WORK_W'(rem_reg - 1'b1);
            if (last)
            begin
                live_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            live_reg <= 1'b0;
            elig_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            live_reg <= live_next;
            elig_reg <= elig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg <= rel_next;
        dl_reg  <= dl_next;
        rem_reg <= rem_next;
        id_reg  <= id_next;
    end

endmodule

@@ hdl/edf_unit_task_scheduler_core.sv @@
// channel   | signals                                         | transfer
// ----------+-------------------------------------------------+--------------------
// command   | func release_day deadline_day work_units        | start && !busy
// result    | kind task_id open_tasks                         | done, one cycle
//
// for each item, the transfer edge latches the command, reads the
// blocked-day memory and registers per-cell eligibility; the next edge does the
// chain insert or the pick and decrement and loads the result registers.
// done is high in the cycle after that; busy is high for one cycle per item.
// after reset the blocked-day memory is cleared one day per cycle, all 2^DAY_BITS
// days (256 by default), with busy held high. results cannot be stalled.
`timescale 1ns / 1ps
`include "edf_unit_task_scheduler_core_assert.svh"

module edf_unit_task_scheduler_core
    import edfs_pkg::*;
#(
    parameter int MAX_TASKS = 64,
    parameter int DAY_BITS  = 8,
    localparam int ID_W      = $clog2(MAX_TASKS + 1),
    localparam int DAY_COUNT = 1 << DAY_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [DAY_BITS-1:0] release_day,
    input  logic [DAY_BITS-1:0] deadline_day,
    input  logic [WORK_W-1:0]   work_units,
    output logic                done,
    output logic [KIND_W-1:0]   kind,
    output logic [ID_W-1:0]     task_id,
    output logic [ID_W-1:0]     open_tasks
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    logic [DAY_BITS-1:0] clr_cnt_reg;
    logic [DAY_BITS-1:0] day_reg;
    logic [ID_W-1:0]     loaded_reg;
    logic [ID_W-1:0]     open_reg;
    logic                op_reg;
    logic                done_reg;
    kind_t               kind_reg;
    logic [ID_W-1:0]     task_id_reg;

    logic [DAY_BITS-1:0] rel_reg;
    logic [DAY_BITS-1:0] dl_reg;
    logic [WORK_W-1:0]   work_reg;
    logic                blk_reg;

    logic                blocked_mem [DAY_COUNT];

    logic                accept;
    logic [DAY_BITS-1:0] day_next;
    logic                full;
    logic [ID_W-1:0]     new_id;
    cell_ctl_t           ctl;

    logic                c_occ  [MAX_TASKS];
    logic                c_live [MAX_TASKS];
    logic [DAY_BITS-1:0] c_rel  [MAX_TASKS];
    logic [DAY_BITS-1:0] c_dl   [MAX_TASKS];
    logic [WORK_W-1:0]   c_rem  [MAX_TASKS];
    logic [ID_W-1:0]     c_id   [MAX_TASKS];
    logic                c_ins  [MAX_TASKS];
    logic                c_hit  [MAX_TASKS];
    logic                c_last [MAX_TASKS];
    logic                found  [MAX_TASKS+1];

    logic [ID_W-1:0]     sel_id;
    logic                sel_last;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign day_next = DAY_BITS'(day_reg + 1'b1);
    assign full     = (loaded_reg == ID_W'(MAX_TASKS));
    assign new_id   = ID_W'(loaded_reg + 1'b1);

    assign ctl.elig_en = accept && (func == FUNC_TICK);
    assign ctl.ins_en  = (state_reg == ST_EXEC) && (op_reg == FUNC_LOAD) && !full
                         && (work_reg != '0);
    assign ctl.dec_en  = (state_reg == ST_EXEC) && (op_reg == FUNC_TICK) && !blk_reg;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        logic                p_occ, p_live, p_ins;
        logic [DAY_BITS-1:0] p_rel, p_dl;
        logic [WORK_W-1:0]   p_rem;
        logic [ID_W-1:0]     p_id;

        if (i == 0)
        begin : g_head
            assign p_occ  = 1'b0;
            assign p_live = 1'b0;
            assign p_ins  = 1'b0;
            assign p_rel  = '0;
            assign p_dl   = '0;
            assign p_rem  = '0;
            assign p_id   = '0;
        end
        else
        begin : g_link
            assign p_occ  = c_occ[i-1];
            assign p_live = c_live[i-1];
            assign p_ins  = c_ins[i-1];
            assign p_rel  = c_rel[i-1];
            assign p_dl   = c_dl[i-1];
            assign p_rem  = c_rem[i-1];
            assign p_id   = c_id[i-1];
        end

        edfs_cell #(
            .DAY_BITS (DAY_BITS),
            .ID_W     (ID_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .check_day (day_next),
            .new_rel   (rel_reg),
            .new_dl    (dl_reg),
            .new_rem   (work_reg),
            .new_id    (new_id),
            .prev_occ  (p_occ),
            .prev_live (p_live),
            .prev_rel  (p_rel),
            .prev_dl   (p_dl),
            .prev_rem  (p_rem),
            .prev_id   (p_id),
            .prev_ins  (p_ins),
            .found_in  (found[i]),
            .occ       (c_occ[i]),
            .live      (c_live[i]),
            .rel       (c_rel[i]),
            .dl        (c_dl[i]),
            .rem       (c_rem[i]),
            .id        (c_id[i]),
            .ins_flag  (c_ins[i]),
            .found_out (found[i+1]),
            .hit       (c_hit[i]),
            .last      (c_last[i])
        );
    end

    // at most one cell hits, so an or of masked fields selects it
    always_comb
    begin
        sel_id   = '0;
        sel_last = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            sel_id   = sel_id | (c_id[i] & {ID_W{c_hit[i]}});
            sel_last = sel_last | (c_last[i] & c_hit[i]);
        end
    end

    // blocked-day memory and latched command payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            blocked_mem[clr_cnt_reg] <= 1'b0;
        end
        else if ((state_reg == ST_EXEC) && (op_reg == FUNC_LOAD) && !full)
        begin
            blocked_mem[dl_reg] <= 1'b1;
        end
        if (accept)
        begin
            blk_reg  <= blocked_mem[day_next];
            rel_reg  <= release_day;
            dl_reg   <= deadline_day;
            work_reg <= work_units;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            day_reg     <= '0;
            loaded_reg  <= '0;
            open_reg    <= '0;
            op_reg      <= FUNC_LOAD;
            done_reg    <= 1'b0;
            kind_reg    <= KIND_IDLE;
            task_id_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= DAY_BITS'(clr_cnt_reg + 1'b1);
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= func;
                        state_reg <= ST_EXEC;
                        if (func == FUNC_TICK)
                        begin
                            day_reg <= day_next;
                        end
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                    if (op_reg == FUNC_LOAD)
                    begin
                        if (full)
                        begin
                            kind_reg    <= KIND_REJECT;
                            task_id_reg <= '0;
                        end
                        else
                        begin
                            kind_reg    <= KIND_ACCEPT;
                            task_id_reg <= new_id;
                            loaded_reg  <= new_id;
                            if (work_reg != '0)
                            begin
                                open_reg <= ID_W'(open_reg + 1'b1);
                            end
                        end
                    end
                    else if (blk_reg)
                    begin
                        kind_reg    <= KIND_DEADLINE;
                        task_id_reg <= '0;
                    end
                    else if (found[MAX_TASKS])
                    begin
                        kind_reg    <= KIND_WORK;
                        task_id_reg <= sel_id;
                        if (sel_last)
                        begin
                            open_reg <= ID_W'(open_reg - 1'b1);
                        end
                    end
                    else
                    begin
                        kind_reg    <= KIND_IDLE;
                        task_id_reg <= '0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign kind       = kind_reg;
    assign task_id    = task_id_reg;
    assign open_tasks = open_reg;

    `EDFS_ASSERT_NEXT(a_accept_then_busy, accept, busy && !done)
    `EDFS_ASSERT_SAME(a_done_only_idle, done, !busy)
    `EDFS_ASSERT_SAME(a_work_has_id, done && (kind_reg == KIND_WORK), task_id != '0)
    `EDFS_ASSERT_SAME(a_open_le_loaded, 1'b1, open_reg <= loaded_reg)

endmodule
